### hw/rtl/mf_pkg.sv
// Shared constants, types and the gray helper function of the 3x3 median filter.
package mf_pkg;

    // Frame limits and derived counter widths.
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // Configuration register widths.
    localparam int IW_W       = 12;
    localparam int IH_W       = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Compare widths wide enough for counter + 1 and for the register value.
    localparam int CW_W = ((COL_W + 1) > IW_W) ? (COL_W + 1) : IW_W;
    localparam int RW_W = ((ROW_W + 1) > IH_W) ? (ROW_W + 1) : IH_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = CFG_IDX_W'(2);

    // Register reset values.
    localparam logic [IW_W-1:0] WIDTH_RST  = IW_W'(640);
    localparam logic [IH_W-1:0] HEIGHT_RST = IH_W'(480);
    localparam logic            MODE_RST   = 1'b0;

    // Window geometry: a position is interior once WIN_SPAN rows and columns
    // have been seen before it.
    localparam int WIN       = 3;
    localparam int WIN_SPAN  = WIN - 1;
    localparam int NUM_LANES = 3;

    // Pixel channel values.
    localparam int CHAN_W     = 8;
    localparam int GRAY_SUM_W = CHAN_W + 5;
    localparam logic [CHAN_W-1:0] WHITE = '1;

    typedef logic [CHAN_W-1:0] t_key;

    typedef struct packed {
        t_key r;
        t_key g;
        t_key b;
    } t_pix;

    // One window column: three pixels, oldest row first, and their gray values.
    typedef struct packed {
        t_pix [WIN-1:0] pix;
        t_key [WIN-1:0] gray;
    } t_col;

    typedef t_key [WIN-1:0]           t_key_col;
    typedef t_key_col [NUM_LANES-1:0] t_lane_keys;

    // One line store entry: the pixel two rows up and the pixel one row up.
    typedef struct packed {
        t_pix upper;
        t_pix lower;
    } t_ls_word;

    // Access commands for the line store.
    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
    } t_ls_cmd;

    // One result item.
    typedef struct packed {
        t_key r;
        t_key g;
        t_key b;
        logic computed;
    } t_res;

    // Gray value (11r + 16g + 5b) / 32, truncated.
    function automatic t_key mf_gray(input t_pix p);
        logic [GRAY_SUM_W-1:0] s;
        s = GRAY_SUM_W'({p.r, 3'b000}) + GRAY_SUM_W'({p.r, 1'b0}) + GRAY_SUM_W'(p.r)
          + GRAY_SUM_W'({p.g, 4'b0000})
          + GRAY_SUM_W'({p.b, 2'b00}) + GRAY_SUM_W'(p.b);
        return s[GRAY_SUM_W-1:5];
    endfunction

endpackage

### hw/rtl/mf_pix_if.sv
// Input pixel channel of the median filter.
interface mf_pix_if;
    logic                      valid;
    logic                      ready;
    logic [mf_pkg::CHAN_W-1:0] red_in;
    logic [mf_pkg::CHAN_W-1:0] green_in;
    logic [mf_pkg::CHAN_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

### hw/rtl/mf_res_if.sv
// Result pixel channel of the median filter.
interface mf_res_if;
    logic                      valid;
    logic                      ready;
    logic [mf_pkg::CHAN_W-1:0] red_out;
    logic [mf_pkg::CHAN_W-1:0] green_out;
    logic [mf_pkg::CHAN_W-1:0] blue_out;
    logic                      computed;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output computed, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input computed, output ready);
endinterface

### hw/rtl/mf_line_store.sv
// Two-row line store with a registered read and write-to-read forwarding.
module mf_line_store (
    input  logic              i_clk,
    input  mf_pkg::t_ls_cmd   i_cmd,
    input  mf_pkg::t_ls_word  i_wr_data,
    output mf_pkg::t_ls_word  o_rd_data
);

    mf_pkg::t_ls_word r_mem [mf_pkg::MAX_WIDTH];
    mf_pkg::t_ls_word r_q;
    mf_pkg::t_ls_word r_fwd;
    logic             r_byp;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_wr_data;
        end
    end

    // Read port. A write to the same entry in the same cycle is forwarded,
    // which happens when a row is one pixel wide.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_q   <= r_mem[i_cmd.rd_addr];
            r_byp <= i_cmd.wr_en && (i_cmd.wr_addr == i_cmd.rd_addr);
            r_fwd <= i_wr_data;
        end
    end

    assign o_rd_data = r_byp ? r_fwd : r_q;

endmodule

### hw/rtl/mf_win_cell.sv
// One column cell of the 3x3 window chain: holds a column and presents its sort keys.
module mf_win_cell (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic               i_color_mode,
    input  mf_pkg::t_col       i_col,
    output mf_pkg::t_col       o_col,
    output mf_pkg::t_lane_keys o_keys
);

    mf_pkg::t_col r_col;

    // Take the neighbor's column on every window shift.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_col <= i_col;
        end
    end

    // In color mode each lane sorts its own channel, in gray mode all sort gray.
    always_comb begin
        for (int r = 0; r < mf_pkg::WIN; r++) begin
            o_keys[0][r] = i_color_mode ? r_col.pix[r].r : r_col.gray[r];
            o_keys[1][r] = i_color_mode ? r_col.pix[r].g : r_col.gray[r];
            o_keys[2][r] = i_color_mode ? r_col.pix[r].b : r_col.gray[r];
        end
    end

    assign o_col = r_col;

endmodule

### hw/rtl/mf_median_lane.sv
// Three-stage median of nine keys: column sort, then row extremes, then median of three.
module mf_median_lane (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  mf_pkg::t_key_col [mf_pkg::WIN-1:0] i_keys,
    output mf_pkg::t_key                   o_med
);

    mf_pkg::t_key r_lo  [mf_pkg::WIN];
    mf_pkg::t_key r_mid [mf_pkg::WIN];
    mf_pkg::t_key r_hi  [mf_pkg::WIN];
    mf_pkg::t_key r_max_lo;
    mf_pkg::t_key r_med_mid;
    mf_pkg::t_key r_min_hi;
    mf_pkg::t_key r_med;

    function automatic mf_pkg::t_key kmin(input mf_pkg::t_key a, input mf_pkg::t_key b);
        return (a < b) ? a : b;
    endfunction

    function automatic mf_pkg::t_key kmax(input mf_pkg::t_key a, input mf_pkg::t_key b);
        return (a < b) ? b : a;
    endfunction

    function automatic mf_pkg::t_key kmed3(input mf_pkg::t_key a, input mf_pkg::t_key b,
                                           input mf_pkg::t_key c);
        return kmax(kmin(a, b), kmin(kmax(a, b), c));
    endfunction

    // Stage 1: sort every column into low, middle and high.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < mf_pkg::WIN; c++) begin
                r_lo[c]  <= kmin(kmin(i_keys[c][0], i_keys[c][1]), i_keys[c][2]);
                r_mid[c] <= kmed3(i_keys[c][0], i_keys[c][1], i_keys[c][2]);
                r_hi[c]  <= kmax(kmax(i_keys[c][0], i_keys[c][1]), i_keys[c][2]);
            end
        end
    end

    // Stage 2: largest low, median of middles, smallest high.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_max_lo  <= kmax(kmax(r_lo[0], r_lo[1]), r_lo[2]);
            r_med_mid <= kmed3(r_mid[0], r_mid[1], r_mid[2]);
            r_min_hi  <= kmin(kmin(r_hi[0], r_hi[1]), r_hi[2]);
        end
    end

    // Stage 3: the median of those three is the median of all nine.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_med <= kmed3(r_max_lo, r_med_mid, r_min_hi);
        end
    end

    assign o_med = r_med;

endmodule

### hw/rtl/median_filter_3x3.sv
// Top level of the 3x3 median filter over a raster RGB pixel stream.
// Every accepted pixel gives exactly one result item, one item per clock unless the output stalls;
// an item reaches the output register through the line store read, the window chain and the
// three compare stages of the median lanes. The output has an output register and a skid
// register, so input stalls only when both hold items.
// Results are the filtered image delayed by width+1 raster positions: the first
// width+1 results of a frame are the white border tail of the previous frame, and
// border positions come out white with computed low. The line store needs no clearing.
module median_filter_3x3 (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    mf_pix_if.sink                         i_pix,
    mf_res_if.source                       o_res
);

    // Configuration registers.
    logic [mf_pkg::IW_W-1:0]  r_width;
    logic [mf_pkg::IH_W-1:0]  r_height;
    logic                     r_color_mode;

    // Position counters of the incoming pixel.
    logic [mf_pkg::COL_W-1:0] r_col;
    logic [mf_pkg::ROW_W-1:0] r_row;

    logic [mf_pkg::CW_W-1:0]  w_lim;
    logic [mf_pkg::RW_W-1:0]  h_lim;
    logic [mf_pkg::CW_W-1:0]  w_col_next;
    logic [mf_pkg::RW_W-1:0]  w_row_next;
    logic                     w_interior;
    logic                     w_en;
    logic                     w_accept;

    // Pipeline stage registers.
    logic                     r_s1_valid;
    logic                     r_s1_int;
    mf_pkg::t_pix             r_s1_px;
    logic [mf_pkg::COL_W-1:0] r_s1_addr;
    logic                     r_s2_valid;
    logic                     r_s2_int;
    logic                     r_s3_valid;
    logic                     r_s3_int;
    logic                     r_s4_valid;
    logic                     r_s4_int;
    logic                     r_s5_valid;
    logic                     r_s5_int;

    // Output and skid registers.
    logic                     r_out_valid;
    mf_pkg::t_res             r_out;
    logic                     r_sk_valid;
    mf_pkg::t_res             r_sk;

    mf_pkg::t_ls_cmd          w_ls_cmd;
    mf_pkg::t_ls_word         w_ls_wr;
    mf_pkg::t_ls_word         w_ls_rd;
    mf_pkg::t_col             w_new_col;
    mf_pkg::t_col             w_cell_in   [mf_pkg::WIN];
    mf_pkg::t_col             w_cell_col  [mf_pkg::WIN];
    mf_pkg::t_lane_keys       w_cell_keys [mf_pkg::WIN];
    mf_pkg::t_key_col [mf_pkg::WIN-1:0] w_lane_in [mf_pkg::NUM_LANES];
    mf_pkg::t_key             w_med [mf_pkg::NUM_LANES];
    mf_pkg::t_res             w_res;
    logic                     w_push;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= mf_pkg::WIDTH_RST;
            r_height     <= mf_pkg::HEIGHT_RST;
            r_color_mode <= mf_pkg::MODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mf_pkg::CFG_IDX_WIDTH:  r_width      <= i_cfg_data[mf_pkg::IW_W-1:0];
                mf_pkg::CFG_IDX_HEIGHT: r_height     <= i_cfg_data[mf_pkg::IH_W-1:0];
                mf_pkg::CFG_IDX_MODE:   r_color_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Frame size limits: zero counts as one, large values saturate.
    always_comb begin
        if (r_width == '0) begin
            w_lim = mf_pkg::CW_W'(1);
        end else if (mf_pkg::CW_W'(r_width) > mf_pkg::CW_W'(mf_pkg::MAX_WIDTH)) begin
            w_lim = mf_pkg::CW_W'(mf_pkg::MAX_WIDTH);
        end else begin
            w_lim = mf_pkg::CW_W'(r_width);
        end
        if (r_height == '0) begin
            h_lim = mf_pkg::RW_W'(1);
        end else if (mf_pkg::RW_W'(r_height) > mf_pkg::RW_W'(mf_pkg::MAX_HEIGHT)) begin
            h_lim = mf_pkg::RW_W'(mf_pkg::MAX_HEIGHT);
        end else begin
            h_lim = mf_pkg::RW_W'(r_height);
        end
    end

    // The incoming pixel completes the window of the position one row and one column back.
    always_comb begin
        w_col_next = mf_pkg::CW_W'(r_col) + mf_pkg::CW_W'(1);
        w_row_next = mf_pkg::RW_W'(r_row) + mf_pkg::RW_W'(1);
        w_interior = (mf_pkg::RW_W'(r_row) >= mf_pkg::RW_W'(mf_pkg::WIN_SPAN))
                  && (w_row_next <= h_lim)
                  && (mf_pkg::CW_W'(r_col) >= mf_pkg::CW_W'(mf_pkg::WIN_SPAN))
                  && (w_col_next <= w_lim);
    end

    // The pipeline moves whenever the skid register is free; no item is taken in reset.
    assign w_en        = !r_sk_valid;
    assign i_pix.ready = w_en && i_rst_n;
    assign w_accept    = i_pix.valid && i_pix.ready;

    // Raster position counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            if (w_col_next >= w_lim) begin
                r_col <= '0;
                r_row <= (w_row_next >= h_lim) ? '0 : w_row_next[mf_pkg::ROW_W-1:0];
            end else begin
                r_col <= w_col_next[mf_pkg::COL_W-1:0];
            end
        end
    end

    // Stage 1 holds the pixel while its line store column is read.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_px   <= '{r: i_pix.red_in, g: i_pix.green_in, b: i_pix.blue_in};
            r_s1_addr <= r_col;
            r_s1_int  <= w_interior;
        end
    end

    // Line store: read on accept, write the shifted column when stage 1 moves on.
    always_comb begin
        w_ls_cmd.rd_en   = w_accept;
        w_ls_cmd.rd_addr = r_col;
        w_ls_cmd.wr_en   = w_en && r_s1_valid;
        w_ls_cmd.wr_addr = r_s1_addr;
        w_ls_wr.upper    = w_ls_rd.lower;
        w_ls_wr.lower    = r_s1_px;
    end

    mf_line_store u_line_store (
        .i_clk     (i_clk),
        .i_cmd     (w_ls_cmd),
        .i_wr_data (w_ls_wr),
        .o_rd_data (w_ls_rd)
    );

    // New window column with its gray values, oldest row first.
    always_comb begin
        w_new_col.pix[0] = w_ls_rd.upper;
        w_new_col.pix[1] = w_ls_rd.lower;
        w_new_col.pix[2] = r_s1_px;
        for (int r = 0; r < mf_pkg::WIN; r++) begin
            w_new_col.gray[r] = mf_pkg::mf_gray(w_new_col.pix[r]);
        end
    end

    // Window chain: the newest column enters the last cell and moves toward cell 0.
    always_comb begin
        for (int c = 0; c < mf_pkg::WIN; c++) begin
            w_cell_in[c] = (c == mf_pkg::WIN - 1) ? w_new_col : w_cell_col[(c + 1) % mf_pkg::WIN];
        end
    end

    for (genvar gc = 0; gc < mf_pkg::WIN; gc++) begin : g_cell
        mf_win_cell u_cell (
            .i_clk        (i_clk),
            .i_en         (w_en && r_s1_valid),
            .i_color_mode (r_color_mode),
            .i_col        (w_cell_in[gc]),
            .o_col        (w_cell_col[gc]),
            .o_keys       (w_cell_keys[gc])
        );
    end

    // Regroup the keys by lane.
    always_comb begin
        for (int l = 0; l < mf_pkg::NUM_LANES; l++) begin
            for (int c = 0; c < mf_pkg::WIN; c++) begin
                w_lane_in[l][c] = w_cell_keys[c][l];
            end
        end
    end

    for (genvar gl = 0; gl < mf_pkg::NUM_LANES; gl++) begin : g_lane
        mf_median_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_keys (w_lane_in[gl]),
            .o_med  (w_med[gl])
        );
    end

    // Valid chain along the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    // Interior flag travels with its item.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_int <= r_s1_int;
            r_s3_int <= r_s2_int;
            r_s4_int <= r_s3_int;
            r_s5_int <= r_s4_int;
        end
    end

    // Finished item: median inside the frame, white on the border.
    always_comb begin
        w_res.r        = r_s5_int ? w_med[0] : mf_pkg::WHITE;
        w_res.g        = r_s5_int ? w_med[1] : mf_pkg::WHITE;
        w_res.b        = r_s5_int ? w_med[2] : mf_pkg::WHITE;
        w_res.computed = r_s5_int;
    end

    assign w_push = w_en && r_s5_valid;

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (o_res.ready || !r_out_valid) begin
            if (r_sk_valid) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end else begin
                r_out_valid <= w_push;
            end
        end else if (w_push) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res.ready || !r_out_valid) begin
            r_out <= r_sk_valid ? r_sk : w_res;
        end else if (w_push) begin
            r_sk <= w_res;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.red_out   = r_out.r;
    assign o_res.green_out = r_out.g;
    assign o_res.blue_out  = r_out.b;
    assign o_res.computed  = r_out.computed;

    // The skid register only holds an item behind a waiting output item.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sk_valid |-> r_out_valid)
        else $error("skid register holds an item with no output item");

    // The skid register fills only when the output item was not taken.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sk_valid) |-> $past(r_out_valid && !o_res.ready))
        else $error("skid register filled while output was free");

    // Border items are white.
    a_border_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.computed) |->
            (o_res.red_out == mf_pkg::WHITE) && (o_res.green_out == mf_pkg::WHITE)
            && (o_res.blue_out == mf_pkg::WHITE))
        else $error("border item is not white");

    // The column counter wraps at the end of a row.
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_col_next >= w_lim)) |=> (r_col == '0))
        else $error("column counter did not wrap at end of row");

endmodule
